// ----- rtl/palette_indexer_rgb555_defines.svh -----
`ifndef PALETTE_INDEXER_RGB555_DEFINES_SVH
`define PALETTE_INDEXER_RGB555_DEFINES_SVH

// Implication or plain property, sampled on the rising clock, off during reset.
`define PALIDX_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PALIDX_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/palidx_pkg.sv -----
`default_nettype none

package palidx_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int IDX_W         = $clog2(PALETTE_DEPTH);
   localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
   localparam int CAP_PACKED    = 16;
   localparam int CAP_INDEX     = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;

   localparam int COLOR_W   = 16;
   localparam int CHAN_W    = 8;
   localparam int ENTRY_W   = 8;
   localparam int MODE_W    = 2;
   localparam int KIND_W    = 2;
   localparam int COLORS_W  = 9;
   localparam int NIB_W     = 4;
   localparam int CMP_W     = (ENTRY_W > CNT_W) ? ENTRY_W : CNT_W;

   localparam logic [COLOR_W-1:0] TRANSPARENT_COLOR = 16'hFFFF;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PIXEL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   // output_mode register
   localparam logic [1:0] OM_PACKED = 2'd0;
   localparam logic [1:0] OM_INDEX  = 2'd1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PACKED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INDEX  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd3;

   // configuration register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_PRESENT = 1'd1;

   // classified operations handed from front to back
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_DIRECT  = 3'd0;
   localparam logic [OP_W-1:0] OP_INDEX   = 3'd1;
   localparam logic [OP_W-1:0] OP_PACK    = 3'd2;
   localparam logic [OP_W-1:0] OP_READ    = 3'd3;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COLOR_W-1:0] color;
      logic               last;
      logic [ENTRY_W-1:0] idx;
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/palidx_front.sv -----
`default_nettype none

module palidx_front (
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [palidx_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [palidx_pkg::CHAN_W-1:0]    req_red,
   input  wire logic [palidx_pkg::CHAN_W-1:0]    req_green,
   input  wire logic [palidx_pkg::CHAN_W-1:0]    req_blue,
   input  wire logic [palidx_pkg::CHAN_W-1:0]    req_alpha,
   input  wire logic                             req_last_pixel,
   input  wire logic [palidx_pkg::ENTRY_W-1:0]   req_entry_index,
   input  wire logic [1:0]                       output_mode,
   input  wire logic                             alpha_present,
   input  wire logic                             q_full,
   output logic                                  push,
   output palidx_pkg::cmd_type                   push_cmd
);
   import palidx_pkg::*;

   logic known_c;

   assign req_ready = !q_full;

   always_comb begin
      push_cmd.color = {1'b0, req_blue[7:3], req_green[7:3], req_red[7:3]};
      if (alpha_present && (req_alpha == '0)) begin
         push_cmd.color = TRANSPARENT_COLOR;
      end
      push_cmd.last = req_last_pixel;
      push_cmd.idx  = req_entry_index;
      known_c       = 1'b1;
      case (req_mode)
         MODE_PIXEL: begin
            case (output_mode)
               OM_PACKED: push_cmd.op = OP_PACK;
               OM_INDEX:  push_cmd.op = OP_INDEX;
               default:   push_cmd.op = OP_DIRECT;
            endcase
         end
         MODE_READ:    push_cmd.op = OP_READ;
         MODE_RESTART: push_cmd.op = OP_RESTART;
         default: begin
            // unknown request: taken and dropped
            push_cmd.op = OP_DIRECT;
            known_c     = 1'b0;
         end
      endcase
   end

   assign push = req_valid && req_ready && known_c;

endmodule

`default_nettype wire

// ----- rtl/palidx_queue.sv -----
`default_nettype none

module palidx_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire palidx_pkg::cmd_type  push_cmd,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      head_valid,
   output palidx_pkg::cmd_type       head_cmd
);
   import palidx_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/palidx_back.sv -----
`default_nettype none
`include "palette_indexer_rgb555_defines.svh"

module palidx_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              head_valid,
   input  wire palidx_pkg::cmd_type               head_cmd,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [palidx_pkg::COLOR_W-1:0]         rsp_value,
   output logic [palidx_pkg::KIND_W-1:0]          rsp_value_kind,
   output logic [palidx_pkg::COLORS_W-1:0]        rsp_colors_used,
   output logic                                   rsp_overflow_error
);
   import palidx_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_RDWAIT = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [COLOR_W-1:0]  mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0]  rd_q_ff;
   logic                rd_zero_ff;
   logic [IDX_W-1:0]    rd_addr_c;
   logic                mem_we_c;

   logic [1:0]          state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic [CNT_W-1:0]    j_ff, j_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [COLOR_W-1:0]  res_val_ff, res_val_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NIB_W-1:0]    held_ff, held_in;
   logic                pend_ff, pend_in;
   logic                ovf_ff, ovf_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [COLORS_W-1:0] rsp_colors_ff, rsp_colors_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic [COLOR_W-1:0]  rd_word_c;
   logic [CNT_W-1:0]    cap_c, limit_c;
   logic                issue_c, hit_c;
   logic                emit_c, out_free_c;
   logic [COLOR_W-1:0]  out_val_c;
   logic [KIND_W-1:0]   out_kind_c;
   logic [NIB_W-1:0]    nib_c;

   // entry 0 is the fixed transparent color and never lives in the array
   assign rd_word_c = rd_zero_ff ? TRANSPARENT_COLOR : rd_q_ff;
   assign cap_c     = (cur_ff.op == OP_PACK) ? CNT_W'(CAP_PACKED) : CNT_W'(CAP_INDEX);
   assign limit_c   = (cnt_ff < cap_c) ? cnt_ff : cap_c;
   assign issue_c   = (state_ff == ST_SEARCH) && (j_ff < limit_c) && !hit_c;
   assign hit_c     = cmp_vld_ff && (rd_word_c == cur_ff.color);
   assign rd_addr_c = (state_ff == ST_IDLE) ? IDX_W'(head_cmd.idx) : IDX_W'(j_ff);
   assign nib_c     = res_val_ff[NIB_W-1:0];
   assign out_free_c = !rsp_valid_ff || rsp_ready;

   always_comb begin
      emit_c     = 1'b1;
      out_val_c  = res_val_ff;
      out_kind_c = KIND_ENTRY;
      case (cur_ff.op)
         OP_PACK: begin
            out_kind_c = KIND_PACKED;
            if (pend_ff) begin
               out_val_c = COLOR_W'({nib_c, held_ff});
            end else if (cur_ff.last) begin
               out_val_c = COLOR_W'(nib_c);
            end else begin
               emit_c = 1'b0;
            end
         end
         OP_INDEX:  out_kind_c = KIND_INDEX;
         OP_DIRECT: out_kind_c = KIND_DIRECT;
         default:   out_kind_c = KIND_ENTRY;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      j_in          = j_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      res_val_in    = res_val_ff;
      cnt_in        = cnt_ff;
      held_in       = held_ff;
      pend_in       = pend_ff;
      ovf_in        = ovf_ff;
      pop           = 1'b0;
      mem_we_c      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_colors_in = rsp_colors_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head_cmd;
               case (head_cmd.op)
                  OP_RESTART: begin
                     cnt_in  = CNT_W'(1);
                     held_in = '0;
                     pend_in = 1'b0;
                     ovf_in  = 1'b0;
                  end
                  OP_READ: begin
                     // read issued this cycle at head_cmd.idx
                     if (CMP_W'(head_cmd.idx) < CMP_W'(cnt_ff)) begin
                        state_in = ST_RDWAIT;
                     end else begin
                        res_val_in = '0;
                        state_in   = ST_FINISH;
                     end
                  end
                  OP_DIRECT: begin
                     res_val_in = head_cmd.color;
                     state_in   = ST_FINISH;
                  end
                  default: begin
                     j_in     = '0;
                     state_in = ST_SEARCH;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            cmp_vld_in = issue_c;
            cmp_idx_in = IDX_W'(j_ff);
            if (issue_c) begin
               j_in = j_ff + 1'b1;
            end
            if (hit_c) begin
               res_val_in = COLOR_W'(cmp_idx_ff);
               state_in   = ST_FINISH;
            end else if (!issue_c && !cmp_vld_ff) begin
               // searched all, no match
               if (cnt_ff < cap_c) begin
                  mem_we_c   = 1'b1;
                  res_val_in = COLOR_W'(cnt_ff);
                  cnt_in     = cnt_ff + 1'b1;
               end else begin
                  ovf_in     = 1'b1;
                  res_val_in = '0;
               end
               state_in = ST_FINISH;
            end
         end
         ST_RDWAIT: begin
            res_val_in = rd_word_c;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!emit_c || out_free_c) begin
               if (cur_ff.op == OP_PACK) begin
                  if (pend_ff || cur_ff.last) begin
                     pend_in = 1'b0;
                     held_in = '0;
                  end else begin
                     pend_in = 1'b1;
                     held_in = nib_c;
                  end
               end
               if (emit_c) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = out_val_c;
                  rsp_kind_in   = out_kind_c;
                  rsp_colors_in = COLORS_W'(cnt_ff);
                  rsp_ovf_in    = ovf_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         cnt_ff       <= CNT_W'(1);
         held_ff      <= '0;
         pend_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         cnt_ff       <= cnt_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      j_ff          <= j_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_val_ff    <= res_val_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_colors_ff <= rsp_colors_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we_c) begin
         mem[IDX_W'(cnt_ff)] <= cur_ff.color;
      end
      rd_q_ff    <= mem[rd_addr_c];
      rd_zero_ff <= (rd_addr_c == '0);
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_value_kind     = rsp_kind_ff;
   assign rsp_colors_used    = rsp_colors_ff;
   assign rsp_overflow_error = rsp_ovf_ff;

   `PALIDX_NEVER(a_cnt_range, clock, reset, (cnt_ff == '0) || (cnt_ff > CNT_W'(CAP_INDEX)), "palette count out of range")
   `PALIDX_ASSERT(a_cnt_step, clock, reset, (cnt_ff > $past(cnt_ff)) |-> (cnt_ff == $past(cnt_ff) + 1'b1), "palette grew by more than one entry")
   `PALIDX_ASSERT(a_ovf_src, clock, reset, $rose(ovf_ff) |-> ($past(state_ff) == ST_SEARCH), "overflow set outside search")
   `PALIDX_ASSERT(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH), "response loaded outside finish")

endmodule

`default_nettype wire

// ----- rtl/palette_indexer_rgb555.sv -----
`default_nettype none

// RGB555 palette indexer. Each request is a pixel (reduced to BGR555, or 0xFFFF when alpha
// is present and zero), a palette read, or an image restart. A front stage classifies
// requests into a two-entry queue; a back sequencer executes them against a 256 x 16
// palette memory with one read port. In the palette modes a pixel walks the live entries
// one per cycle until it finds a match or runs out of entries; restarts produce no
// response. The palette capacity is 16 in packed mode (two indices per byte, low nibble
// first) and 256 in index mode; a color that does not fit sets the sticky overflow
// flag and yields index 0. No clearing pass is needed after reset.
// output_mode and alpha_present may only be written while the block is idle.
module palette_indexer_rgb555 (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [palidx_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [palidx_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [palidx_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [palidx_pkg::CHAN_W-1:0]      req_red,
   input  wire logic [palidx_pkg::CHAN_W-1:0]      req_green,
   input  wire logic [palidx_pkg::CHAN_W-1:0]      req_blue,
   input  wire logic [palidx_pkg::CHAN_W-1:0]      req_alpha,
   input  wire logic                               req_last_pixel,
   input  wire logic [palidx_pkg::ENTRY_W-1:0]     req_entry_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [palidx_pkg::COLOR_W-1:0]          rsp_value,
   output logic [palidx_pkg::KIND_W-1:0]           rsp_value_kind,
   output logic [palidx_pkg::COLORS_W-1:0]         rsp_colors_used,
   output logic                                    rsp_overflow_error
);
   import palidx_pkg::*;

   logic [1:0] output_mode_ff, output_mode_in;
   logic       alpha_present_ff, alpha_present_in;

   logic       q_full;
   logic       push;
   cmd_type    push_cmd;
   logic       pop;
   logic       head_valid;
   cmd_type    head_cmd;

   always_comb begin
      output_mode_in   = output_mode_ff;
      alpha_present_in = alpha_present_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OUTPUT_MODE:   output_mode_in   = csr_wdata[1:0];
            CSR_ALPHA_PRESENT: alpha_present_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_mode_ff   <= OM_INDEX;
         alpha_present_ff <= 1'b1;
      end else begin
         output_mode_ff   <= output_mode_in;
         alpha_present_ff <= alpha_present_in;
      end
   end

   palidx_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .req_last_pixel  (req_last_pixel),
      .req_entry_index (req_entry_index),
      .output_mode     (output_mode_ff),
      .alpha_present   (alpha_present_ff),
      .q_full          (q_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   palidx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   palidx_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_value          (rsp_value),
      .rsp_value_kind     (rsp_value_kind),
      .rsp_colors_used    (rsp_colors_used),
      .rsp_overflow_error (rsp_overflow_error)
   );

endmodule

`default_nettype wire
